FILE: sv/efe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and byte codes for the escaped frame encoder.
// ----------------------------------------------------------------------------
package efe_pkg;

	localparam logic [7:0] START_BYTE = 8'h1a;
	localparam logic [7:0] ESC_BYTE   = 8'h1b;
	localparam logic [7:0] STOP_BYTE  = 8'h1c;
	localparam logic [7:0] ESC_BASE   = 8'h19;
	localparam logic [7:0] ERR_BYTE   = 8'h00;

	localparam logic CMD_OPEN = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam int unsigned MAX_RESULTS = 4;

	typedef logic [1:0] res_idx_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		res_idx_t                    last_idx;
		logic                        stop;
		logic                        err;
	} burst_t;

endpackage
`default_nettype wire

FILE: sv/efe_encode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efe_encode
// Frame state and byte escaping; turns one input item into a burst of bytes.
// ----------------------------------------------------------------------------
module efe_encode import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       command,
	input  wire logic [7:0] frame_code,
	input  wire logic [7:0] payload_len,
	input  wire logic [7:0] data_byte,
	output burst_t          burst
);

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic       frame_open_d;
	logic [7:0] bytes_left_d;
	logic [7:0] left_dec;
	logic       closing;
	logic       esc;

	always_comb begin
		left_dec     = bytes_left_q - 8'd1;
		closing      = (left_dec == 8'd0);
		esc          = (data_byte == START_BYTE) || (data_byte == ESC_BYTE) ||
		               (data_byte == STOP_BYTE);
		burst        = '0;
		frame_open_d = frame_open_q;
		bytes_left_d = bytes_left_q;
		if (command == CMD_OPEN) begin
			if (frame_open_q) begin
				burst.bytes[0] = ERR_BYTE;
				burst.err      = 1'b1;
			end else begin
				burst.bytes[0] = START_BYTE;
				burst.bytes[1] = frame_code;
				burst.bytes[2] = payload_len;
				burst.bytes[3] = STOP_BYTE;
				if (payload_len == 8'd0) begin
					burst.last_idx = res_idx_t'(3);
					burst.stop     = 1'b1;
				end else begin
					burst.last_idx = res_idx_t'(2);
					frame_open_d   = 1'b1;
					bytes_left_d   = payload_len;
				end
			end
		end else begin
			if (!frame_open_q) begin
				burst.bytes[0] = ERR_BYTE;
				burst.err      = 1'b1;
			end else begin
				bytes_left_d = left_dec;
				burst.stop   = closing;
				if (closing) begin
					frame_open_d = 1'b0;
				end
				if (esc) begin
					burst.bytes[0] = data_byte - ESC_BASE;
					burst.bytes[1] = ESC_BYTE;
					burst.bytes[2] = STOP_BYTE;
					burst.last_idx = closing ? res_idx_t'(2) : res_idx_t'(1);
				end else begin
					burst.bytes[0] = data_byte;
					burst.bytes[1] = STOP_BYTE;
					burst.last_idx = closing ? res_idx_t'(1) : res_idx_t'(0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'd0;
		end else if (accept) begin
			frame_open_q <= frame_open_d;
			bytes_left_q <= bytes_left_d;
		end
	end

`ifndef SYNTHESIS
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (bytes_left_q != 8'd0))
		else $error("open frame with no bytes left");
	a_closed_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_open_q |-> (bytes_left_q == 8'd0))
		else $error("closed frame with bytes left");
`endif

endmodule
`default_nettype wire

FILE: sv/efe_burst_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efe_burst_out
// Result register; sends a stored burst one byte per output transaction.
// ----------------------------------------------------------------------------
module efe_burst_out import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire burst_t     burst,
	output logic            can_load,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_end,
	output logic            error
);

	burst_t   burst_s1;
	logic     valid_q;
	res_idx_t idx_q;
	logic     take;
	logic     done;

	always_comb begin
		take      = valid_q && out_ready;
		done      = take && (idx_q == burst_s1.last_idx);
		can_load  = !valid_q || done;
		out_valid = valid_q;
		out_byte  = burst_s1.bytes[idx_q];
		run_last  = (idx_q == burst_s1.last_idx);
		frame_end = run_last && burst_s1.stop;
		error     = burst_s1.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + res_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_s1 <= burst;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= burst_s1.last_idx))
		else $error("result index past end of burst");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && burst_s1.err) |-> (burst_s1.last_idx == res_idx_t'(0)))
		else $error("error burst longer than one result");
`endif

endmodule
`default_nettype wire

FILE: sv/escaped_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_encoder
// Frame builder for a byte-stuffed serial link.
//
// The input channel (in_valid/in_ready) takes one item per transaction: an
// open with a frame code and payload length, or one payload byte. The output
// channel (out_valid/out_ready) gives one line byte per transaction, with
// run_last on the final byte an item causes, frame_end on a stop byte and
// error on the single result of a rejected item.
// An item accepted at one edge shows its first byte in the next cycle. Each
// item gives one to four bytes and the output port moves one byte a cycle
// while out_ready is high; the next item is accepted in the cycle the last
// byte of the current one is taken.
// Reset closes any frame and empties the result register. When the receiver
// stalls, the current byte holds and in_ready stays low once the result
// register still has bytes left to send.
// ----------------------------------------------------------------------------
module escaped_frame_encoder import efe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       command,
	input  wire logic [7:0] frame_code,
	input  wire logic [7:0] payload_len,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            frame_end,
	output logic            error
);

	burst_t burst;
	logic   can_load;
	logic   accept;

	assign in_ready = can_load;
	assign accept   = in_valid && can_load;

	efe_encode u_encode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.frame_code  (frame_code),
		.payload_len (payload_len),
		.data_byte   (data_byte),
		.burst       (burst)
	);

	efe_burst_out u_burst_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.burst     (burst),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end),
		.error     (error)
	);

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the escaped frame encoder.
//
// Open and payload items are driven on the input channel. A scoreboard
// predicts the line bytes each accepted item should cause and checks every
// output transaction against them in order. The run starts with a directed
// pass over zero-length frames, escaped bytes and rejected items. A full
// 255-byte frame follows, and then randomized frames mixed with stray
// payloads and opens inside frames. Both channels stall at random, and there
// is one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb;
	import efe_pkg::*;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last;
		logic       stop;
		logic       err;
	} line_result_t;

	class frame_scoreboard;
		logic         frame_open;
		logic [7:0]   bytes_left;
		line_result_t line_bytes_due[$];
		int unsigned  fail_count;
		int unsigned  item_count;
		int unsigned  byte_count;
		int unsigned  reject_count;
		int unsigned  escape_count;
		int unsigned  frame_count;

		function new();
			frame_open = 1'b0;
			bytes_left = 8'd0;
			fail_count = 0;
			item_count = 0;
			byte_count = 0;
			reject_count = 0;
			escape_count = 0;
			frame_count = 0;
		endfunction

		function void push(logic [7:0] b, logic last, logic stop, logic err);
			line_bytes_due.push_back('{b, last, stop, err});
		endfunction

		function void note_item(logic cmd, logic [7:0] code, logic [7:0] len,
				logic [7:0] data);
			logic closing;
			item_count++;
			if (cmd == CMD_OPEN) begin
				if (frame_open) begin
					push(ERR_BYTE, 1'b1, 1'b0, 1'b1);
					reject_count++;
				end else begin
					push(START_BYTE, 1'b0, 1'b0, 1'b0);
					push(code, 1'b0, 1'b0, 1'b0);
					if (len == 8'd0) begin
						push(len, 1'b0, 1'b0, 1'b0);
						push(STOP_BYTE, 1'b1, 1'b1, 1'b0);
						frame_count++;
					end else begin
						push(len, 1'b1, 1'b0, 1'b0);
						frame_open = 1'b1;
						bytes_left = len;
					end
				end
			end else if (!frame_open) begin
				push(ERR_BYTE, 1'b1, 1'b0, 1'b1);
				reject_count++;
			end else begin
				bytes_left = bytes_left - 8'd1;
				closing = (bytes_left == 8'd0);
				if (data == START_BYTE || data == ESC_BYTE || data == STOP_BYTE) begin
					push(data - ESC_BASE, 1'b0, 1'b0, 1'b0);
					push(ESC_BYTE, !closing, 1'b0, 1'b0);
					escape_count++;
				end else begin
					push(data, !closing, 1'b0, 1'b0);
				end
				if (closing) begin
					push(STOP_BYTE, 1'b1, 1'b1, 1'b0);
					frame_open = 1'b0;
					frame_count++;
				end
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %02h, got %02h", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_byte(logic [7:0] b, logic last, logic stop, logic err);
			line_result_t want;
			if (line_bytes_due.size() == 0) begin
				$error("unexpected transaction: out_byte %02h", b);
				fail_count++;
				return;
			end
			want = line_bytes_due.pop_front();
			byte_count++;
			compare_field("out_byte", want.line_byte, b);
			compare_field("run_last", want.last, last);
			compare_field("frame_end", want.stop, stop);
			compare_field("error", want.err, err);
		endfunction

		function int pending();
			return line_bytes_due.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       command = CMD_OPEN;
	logic [7:0] frame_code = 8'd0;
	logic [7:0] payload_len = 8'd0;
	logic [7:0] data_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       error;

	bit              idle_en = 1'b1;
	int unsigned     hold_req = 0;
	frame_scoreboard sb = new();

	escaped_frame_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.frame_code (frame_code),
		.payload_len(payload_len),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end),
		.error      (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic cmd, input logic [7:0] code,
			input logic [7:0] len, input logic [7:0] data);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		frame_code  <= code;
		payload_len <= len;
		data_byte   <= data;
		do @(posedge clk); while (!in_ready);
		sb.note_item(cmd, code, len, data);
	endtask

	function automatic logic [7:0] pick_payload();
		if ($urandom_range(0, 9) < 3)
			return START_BYTE + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame(input logic [7:0] len, input bit noisy);
		send_item(CMD_OPEN, 8'($urandom_range(0, 255)), len, 8'($urandom_range(0, 255)));
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, len) == 0)
				send_item(CMD_OPEN, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			send_item(CMD_DATA, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), pick_payload());
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : line_sink
		int unsigned hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_byte(out_byte, run_last, frame_end, error);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (idle_en && arst_n && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				hold_left = $urandom_range(0, 9);
			end else begin
				out_ready <= arst_n;
			end
		end
	end

	initial begin : stimulus
		int unsigned first_item;
		bit          hold_sent = 1'b0;
		bit          drain_done = 1'b0;
		logic [7:0]  len;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_DATA, 8'h00, 8'h00, 8'h55);
		send_item(CMD_OPEN, 8'hff, 8'h00, 8'h00);
		send_item(CMD_OPEN, 8'h00, 8'h00, 8'hff);
		send_item(CMD_OPEN, 8'ha5, 8'h05, 8'h00);
		send_item(CMD_DATA, 8'h00, 8'h00, START_BYTE);
		send_item(CMD_DATA, 8'h00, 8'h00, ESC_BYTE);
		send_item(CMD_OPEN, 8'h12, 8'h34, 8'h56);
		send_item(CMD_DATA, 8'hff, 8'hff, STOP_BYTE);
		send_item(CMD_DATA, 8'h00, 8'h00, 8'h19);
		send_item(CMD_DATA, 8'h00, 8'h00, 8'h1d);
		send_item(CMD_OPEN, 8'h5a, 8'h01, 8'h00);
		send_item(CMD_DATA, 8'h00, 8'h00, ESC_BYTE);
		send_item(CMD_OPEN, 8'h3c, 8'h02, 8'h00);
		send_item(CMD_DATA, 8'h00, 8'h00, 8'hff);
		send_item(CMD_DATA, 8'h00, 8'h00, START_BYTE);
		send_item(CMD_OPEN, 8'h01, 8'h01, 8'h00);
		send_item(CMD_DATA, 8'h00, 8'h00, 8'h00);
		send_item(CMD_OPEN, 8'h80, 8'h01, 8'h00);
		send_item(CMD_DATA, 8'h00, 8'h00, STOP_BYTE);
		send_item(CMD_DATA, 8'hff, 8'hff, START_BYTE);

		send_frame(8'hff, 1'b0);

		first_item = sb.item_count;
		while (sb.item_count - first_item < 75) begin
			if (!hold_sent && sb.item_count - first_item >= 10) begin
				hold_req = 150;
				hold_sent = 1'b1;
			end
			if (!drain_done && sb.item_count - first_item >= 35) begin
				drain_results();
				drain_done = 1'b1;
			end
			if (sb.item_count - first_item > 55)
				idle_en = 1'b0;
			if ($urandom_range(0, 9) == 0)
				send_item(CMD_DATA, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), pick_payload());
			if ($urandom_range(0, 9) == 0)
				len = 8'd0;
			else if ($urandom_range(0, 19) == 0)
				len = 8'($urandom_range(13, 40));
			else
				len = 8'($urandom_range(1, 12));
			send_frame(len, $urandom_range(0, 7) == 0);
		end

		drain_results();
		repeat (20) @(posedge clk);
		$display("Run covered %0d items and %0d line bytes: %0d frames closed,",
			sb.item_count, sb.byte_count, sb.frame_count);
		$display("%0d escaped payload bytes and %0d rejected items.",
			sb.escape_count, sb.reject_count);
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
